@@ hw/rtl/mmm_pkg.sv @@
package mmm_pkg;

	localparam int LIMBS     = 4;
	localparam int LIMB_W    = 64;
	localparam int HALF_W    = LIMB_W / 2;
	localparam int DATA_W    = LIMBS * LIMB_W;
	// A product or a reduced sum needs one bit above two full operands.
	localparam int ACC_W     = 2 * DATA_W + 1;
	localparam int RES_W     = DATA_W + 1;
	localparam int CELL_LAT  = 4;
	localparam int FINAL_LAT = 3;
	// Product chain, then a quotient cell and a reduction cell for each limb.
	localparam int LATENCY   = 3 * LIMBS * CELL_LAT + FINAL_LAT;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIME0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIME1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIME2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIME3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NINV   = 3'd4;

	typedef struct packed {
		logic              kind;
		logic [LIMB_W-1:0] a_limb0;
		logic [LIMB_W-1:0] a_limb1;
		logic [LIMB_W-1:0] a_limb2;
		logic [LIMB_W-1:0] a_limb3;
		logic [LIMB_W-1:0] b_limb0;
		logic [LIMB_W-1:0] b_limb1;
		logic [LIMB_W-1:0] b_limb2;
		logic [LIMB_W-1:0] b_limb3;
	} in_t;

	typedef struct packed {
		logic [LIMB_W-1:0] result_limb0;
		logic [LIMB_W-1:0] result_limb1;
		logic [LIMB_W-1:0] result_limb2;
		logic [LIMB_W-1:0] result_limb3;
		logic              out_of_range;
	} out_t;

endpackage

@@ hw/rtl/montgomery_mod_multiply_top.sv @@
// Channel   | Signals                                   | Transfer
// ----------+-------------------------------------------+--------------------------------
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready high
// operand   | start, busy, operand                      | start high while busy is low
// result    | done, result                              | done high, one cycle, no stall
//
// The unit is fully pipelined: busy stays low and a new operand may be given in every cycle.
// The path from each operand transfer to its result runs through the chain of twelve
// four-stage multiply cells and the three-stage final correction.
// Reset clears the configuration registers and every valid bit in the pipeline.
// The receiver cannot stall, so results leave in operand order, one per operand.
module montgomery_mod_multiply_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mmm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mmm_pkg::LIMB_W-1:0]     cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  mmm_pkg::in_t                   operand,
	output logic                           done,
	output mmm_pkg::out_t                  result
);
	import mmm_pkg::*;

	logic [LIMB_W-1:0] prime_q [LIMBS];
	logic [LIMB_W-1:0] ninv_q;
	logic [DATA_W-1:0] prime_vec;
	logic [RES_W-1:0]  prime_ext;

	// Product chain signals: the side word carries kind, b and a alongside the sum.
	logic              pvld [LIMBS+1];
	logic [ACC_W-1:0]  pacc [LIMBS+1];
	logic [ACC_W-1:0]  pside [LIMBS+1];
	logic [LIMB_W-1:0] px [LIMBS];

	// Reduction chain signals.
	logic              rvld [LIMBS+1];
	logic [ACC_W-1:0]  tacc [LIMBS+1];
	logic              qvld [LIMBS];
	logic [LIMB_W-1:0] quot [LIMBS];
	logic [ACC_W-1:0]  qside [LIMBS];

	logic              vld_s1, vld_s2, done_q;
	logic [RES_W-1:0]  v_s1, r_s2;
	logic              ge_s1;
	out_t              result_q;
	logic [DATA_W-1:0] a_vec, b_vec;
	logic              accept;

	// Configuration writes are always taken; an index beyond the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIMBS; i++) begin
				prime_q[i] <= '0;
			end
			ninv_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRIME0: prime_q[0] <= cfg_data;
				CFG_PRIME1: prime_q[1] <= cfg_data;
				CFG_PRIME2: prime_q[2] <= cfg_data;
				CFG_PRIME3: prime_q[3] <= cfg_data;
				CFG_NINV:   ninv_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < LIMBS; i++) begin
			prime_vec[LIMB_W*i +: LIMB_W] = prime_q[i];
		end
	end

	assign prime_ext = {1'b0, prime_vec};

	// The pipeline never holds an operand back.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign a_vec = {operand.a_limb3, operand.a_limb2, operand.a_limb1, operand.a_limb0};
	assign b_vec = {operand.b_limb3, operand.b_limb2, operand.b_limb1, operand.b_limb0};

	// In reduce mode the sum starts as b:a and every product cell adds zero; in multiply
	// mode it starts at zero and cell i adds a_i * b shifted by i limbs.
	assign pvld[0]  = accept;
	assign pacc[0]  = operand.kind ? {1'b0, b_vec, a_vec} : '0;
	assign pside[0] = {operand.kind, b_vec, a_vec};

	for (genvar i = 0; i < LIMBS; i++) begin : g_prod
		assign px[i] = pside[i][ACC_W-1] ? '0 : pside[i][LIMB_W*i +: LIMB_W];

		mmm_cell #(
			.YW    (DATA_W),
			.ACCW  (ACC_W),
			.SHIFT (LIMB_W * i),
			.SW    (ACC_W)
		) u_prod (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (pvld[i]),
			.mul_x    (px[i]),
			.mul_y    (pside[i][2*DATA_W-1:DATA_W]),
			.acc      (pacc[i]),
			.side     (pside[i]),
			.res_vld  (pvld[i+1]),
			.res      (pacc[i+1]),
			.res_side (pside[i+1])
		);
	end

	assign rvld[0] = pvld[LIMBS];
	assign tacc[0] = pacc[LIMBS];

	// Each limb of the reduction takes two cells: one forms the quotient digit
	// m = t_i * ninv mod 2^64, the next adds m * p shifted by i limbs.
	for (genvar i = 0; i < LIMBS; i++) begin : g_redc
		mmm_cell #(
			.YW    (LIMB_W),
			.ACCW  (LIMB_W),
			.SHIFT (0),
			.SW    (ACC_W)
		) u_quot (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (rvld[i]),
			.mul_x    (tacc[i][LIMB_W*i +: LIMB_W]),
			.mul_y    (ninv_q),
			.acc      ('0),
			.side     (tacc[i]),
			.res_vld  (qvld[i]),
			.res      (quot[i]),
			.res_side (qside[i])
		);

		mmm_cell #(
			.YW    (DATA_W),
			.ACCW  (ACC_W),
			.SHIFT (LIMB_W * i),
			.SW    (1)
		) u_redc (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (qvld[i]),
			.mul_x    (quot[i]),
			.mul_y    (prime_vec),
			.acc      (qside[i]),
			.side     (1'b0),
			.res_vld  (rvld[i+1]),
			.res      (tacc[i+1]),
			.res_side ()
		);
	end

	// The upper half plus its carry bit is the unreduced result; one conditional
	// subtraction follows, then the range check on what remains.
	always_ff @(posedge clk) begin
		v_s1  <= tacc[LIMBS][ACC_W-1:DATA_W];
		ge_s1 <= tacc[LIMBS][ACC_W-1:DATA_W] >= prime_ext;
		r_s2  <= ge_s1 ? (v_s1 - prime_ext) : v_s1;
		result_q.result_limb0 <= r_s2[LIMB_W*0 +: LIMB_W];
		result_q.result_limb1 <= r_s2[LIMB_W*1 +: LIMB_W];
		result_q.result_limb2 <= r_s2[LIMB_W*2 +: LIMB_W];
		result_q.result_limb3 <= r_s2[LIMB_W*3 +: LIMB_W];
		result_q.out_of_range <= r_s2 >= prime_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= rvld[LIMBS];
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Every transfer yields its result after exactly the pipeline latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result missing after operand transfer");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching operand transfer");

	// A result flagged in range must lie below the modulus.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.out_of_range) |->
		({result.result_limb3, result.result_limb2, result.result_limb1,
		  result.result_limb0} < prime_vec))
		else $error("in-range result not below modulus");

	// With a zero modulus nothing can be below it.
	a_zero_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (prime_vec == '0)) |-> result.out_of_range)
		else $error("zero modulus without range flag");

endmodule

@@ hw/rtl/mmm_cell.sv @@
module mmm_cell #(
	parameter int YW    = mmm_pkg::DATA_W,
	parameter int ACCW  = mmm_pkg::ACC_W,
	parameter int SHIFT = 0,
	parameter int SW    = mmm_pkg::ACC_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld,
	input  logic [mmm_pkg::LIMB_W-1:0]  mul_x,
	input  logic [YW-1:0]               mul_y,
	input  logic [ACCW-1:0]             acc,
	input  logic [SW-1:0]               side,
	output logic                        res_vld,
	output logic [ACCW-1:0]             res,
	output logic [SW-1:0]               res_side
);
	import mmm_pkg::*;

	localparam int NY = YW / HALF_W;
	localparam int NP = NY / 2;
	localparam int PW = YW + LIMB_W;

	logic [LIMB_W-1:0] plo_s1 [NY];
	logic [LIMB_W-1:0] phi_s1 [NY];
	logic [ACCW-1:0]   acc_s1, acc_s2, acc_s3, acc_s4;
	logic [SW-1:0]     side_s1, side_s2, side_s3, side_s4;
	logic [YW-1:0]     row_le, row_lo, row_he, row_ho;
	logic [PW-1:0]     sa_s2, sb_s2, prod_s3;
	logic              vld_s1, vld_s2, vld_s3, vld_s4;

	// Each half of x times each 32-bit word of y.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NY; k++) begin
			plo_s1[k] <= LIMB_W'(mul_x[HALF_W-1:0]) * LIMB_W'(mul_y[HALF_W*k +: HALF_W]);
			phi_s1[k] <= LIMB_W'(mul_x[LIMB_W-1:HALF_W]) * LIMB_W'(mul_y[HALF_W*k +: HALF_W]);
		end
		acc_s1  <= acc;
		side_s1 <= side;
	end

	// Even and odd word products do not overlap, so each set forms one row.
	always_comb begin
		for (int j = 0; j < NP; j++) begin
			row_le[LIMB_W*j +: LIMB_W] = plo_s1[2*j];
			row_lo[LIMB_W*j +: LIMB_W] = plo_s1[2*j+1];
			row_he[LIMB_W*j +: LIMB_W] = phi_s1[2*j];
			row_ho[LIMB_W*j +: LIMB_W] = phi_s1[2*j+1];
		end
	end

	always_ff @(posedge clk) begin
		sa_s2   <= PW'(row_le) + (PW'(row_lo) << HALF_W);
		sb_s2   <= PW'(row_he) + (PW'(row_ho) << HALF_W);
		acc_s2  <= acc_s1;
		side_s2 <= side_s1;
		prod_s3 <= sa_s2 + (sb_s2 << HALF_W);
		acc_s3  <= acc_s2;
		side_s3 <= side_s2;
		acc_s4  <= acc_s3 + (ACCW'(prod_s3) << SHIFT);
		side_s4 <= side_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign res_vld  = vld_s4;
	assign res      = acc_s4;
	assign res_side = side_s4;

endmodule
